// ----- rtl/wtsp_pkg.sv -----
// ----------------------------------------------------------------------------
// wtsp_pkg
// shared constants and codes for the world to screen projection unit
// ----------------------------------------------------------------------------
package wtsp_pkg;

  localparam int unsigned COORD_W     = 32;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned VIEW_W      = 15;

  localparam int unsigned NDC_LIMIT_LOG2 = 40;
  localparam int unsigned QUO_W          = NDC_LIMIT_LOG2 + 1;

  localparam logic signed [COORD_W-1:0] HIDDEN_SCALE = 32'sd100000;
  localparam logic signed [COORD_W-1:0] HIDDEN_LIMIT = 32'sd21474;
  localparam logic signed [COORD_W-1:0] COORD_MAX    = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] COORD_MIN    = 32'sh8000_0000;

  localparam logic [VIEW_W-1:0] WIDTH_RESET  = 15'd1920;
  localparam logic [VIEW_W-1:0] HEIGHT_RESET = 15'd1080;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ROW0_A = 3'd0,
    CFG_ROW0_B = 3'd1,
    CFG_ROW1_A = 3'd2,
    CFG_ROW1_B = 3'd3,
    CFG_ROW3_A = 3'd4,
    CFG_ROW3_B = 3'd5,
    CFG_WIDTH  = 3'd6,
    CFG_HEIGHT = 3'd7
  } cfg_index_e;

endpackage

// ----- rtl/wtsp_if.sv -----
// ----------------------------------------------------------------------------
// wtsp channel interfaces
// valid/ready channels for world points and screen results
// ----------------------------------------------------------------------------
interface wtsp_point_if;
  import wtsp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface wtsp_screen_if;
  import wtsp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] screen_x;
  logic signed [COORD_W-1:0] screen_y;
  logic                      visible;
  modport source (output valid, screen_x, screen_y, visible, input ready);
  modport sink   (input valid, screen_x, screen_y, visible, output ready);
endinterface

// ----- rtl/world_to_screen_projection_unit.sv -----
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit
// fixed point perspective projection of world points to pixel coordinates
// ----------------------------------------------------------------------------
// Usage: world points arrive on point_i and screen results leave on screen_o,
// both valid/ready channels; a transfer happens when valid and ready are high.
// The view matrix rows 0, 1 and 3 and the viewport size are written through
// the cfg port (cfg_we_i, cfg_index_i, cfg_data_i) while the block is idle.
// Throughput: one point per cycle, sustained while the receiver does not stall.
// Pipeline from input transfer to result valid: products, sums, divider setup,
// one quotient bit per stage of the restoring divider, then offset, viewport
// multiply and saturation.
// Reset clears all stage valid bits, the matrix to zero and the viewport to
// 1920 by 1080. When the receiver stalls with a result waiting, the whole
// pipeline holds and point_i.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module world_to_screen_projection_unit #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wtsp_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [wtsp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  wtsp_point_if.sink                          point_i,
  wtsp_screen_if.source                       screen_o
);
  import wtsp_pkg::*;

  localparam int unsigned CW    = 66 - FRACTION_BITS;
  localparam int unsigned RW    = CW + 1;
  localparam int unsigned NPW   = CW + FRACTION_BITS;
  localparam int unsigned TW    = QUO_W + 2;
  localparam int unsigned PW    = TW + VIEW_W + 1;
  localparam logic signed [CW-1:0] W_MIN =
    CW'((64'd1 << FRACTION_BITS) + 64'd999) / 1000;
  localparam logic signed [TW-1:0] ONE = TW'(64'd1 << FRACTION_BITS);
  localparam logic [QUO_W-1:0] NDC_LIMIT = QUO_W'(1) << NDC_LIMIT_LOG2;

  typedef struct packed {
    logic                      valid;
    logic                      hidden;
    logic signed [COORD_W-1:0] hx;
    logic signed [COORD_W-1:0] hy;
    logic                      sx;
    logic                      sy;
    logic [CW-1:0]             d;
    logic [RW-1:0]             rx;
    logic [RW-1:0]             ry;
    logic [QUO_W-1:0]          remx;
    logic [QUO_W-1:0]          remy;
    logic [QUO_W-1:0]          qx;
    logic [QUO_W-1:0]          qy;
    logic                      ovx;
    logic                      ovy;
  } div_t;

  // configuration
  logic [CFG_DATA_W-1:0] pair_q [6];
  logic [VIEW_W-1:0]     width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) pair_q[i] <= '0;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i)) inside
        CFG_ROW0_A, CFG_ROW0_B, CFG_ROW1_A, CFG_ROW1_B, CFG_ROW3_A, CFG_ROW3_B: begin
          pair_q[cfg_index_i] <= cfg_data_i;
        end
        CFG_WIDTH:  width_q  <= cfg_data_i[VIEW_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[VIEW_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [COORD_W-1:0] coef [3][4];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = pair_q[2*r][63:32];
      coef[r][1] = pair_q[2*r][31:0];
      coef[r][2] = pair_q[2*r+1][63:32];
      coef[r][3] = pair_q[2*r+1][31:0];
    end
  end

  // pipeline advance
  logic adv;
  logic out_valid_q;
  assign adv           = !out_valid_q || screen_o.ready;
  assign point_i.ready = adv;

  // stage 1: products
  logic                  s1_valid_q;
  logic signed [63:0]    prod_q [3][3];
  logic signed [COORD_W-1:0] pt [3];
  assign pt[0] = point_i.point_x;
  assign pt[1] = point_i.point_y;
  assign pt[2] = point_i.point_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else if (adv) s1_valid_q <= point_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) prod_q[r][k] <= coef[r][k] * pt[k];
      end
    end
  end

  // stage 2: clip coordinates
  logic               s2_valid_q;
  logic signed [CW-1:0] clip_q [3];
  logic signed [CW-1:0] clip_d [3];
  logic signed [65:0]   sum    [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r]    = 66'(prod_q[r][0]) + 66'(prod_q[r][1]) + 66'(prod_q[r][2]);
      clip_d[r] = CW'(sum[r] >>> FRACTION_BITS) + CW'(coef[r][3]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_valid_q <= 1'b0;
    else if (adv) s2_valid_q <= s1_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) clip_q[r] <= clip_d[r];
    end
  end

  // stage 3: hidden scaling and divider setup
  function automatic logic signed [COORD_W-1:0] hid_scale(input logic signed [CW-1:0] c);
    logic signed [COORD_W-1:0] res;
    if (c > CW'(HIDDEN_LIMIT)) res = COORD_MAX;
    else if (c < -CW'(HIDDEN_LIMIT)) res = COORD_MIN;
    else res = COORD_W'(c) * HIDDEN_SCALE;
    return res;
  endfunction

  div_t dv_q [QUO_W+1];
  div_t dv_d [QUO_W+1];

  logic [CW-1:0]  magx, magy;
  logic [NPW-1:0] npx, npy;
  logic [RW-1:0]  r0x, r0y;

  always_comb begin
    magx = clip_q[0][CW-1] ? CW'(-clip_q[0]) : CW'(clip_q[0]);
    magy = clip_q[1][CW-1] ? CW'(-clip_q[1]) : CW'(clip_q[1]);
    npx  = {magx, {FRACTION_BITS{1'b0}}};
    npy  = {magy, {FRACTION_BITS{1'b0}}};
    r0x  = RW'(npx[NPW-1:QUO_W]);
    r0y  = RW'(npy[NPW-1:QUO_W]);
    dv_d[0].valid  = s2_valid_q;
    dv_d[0].hidden = clip_q[2] < W_MIN;
    dv_d[0].hx     = hid_scale(clip_q[0]);
    dv_d[0].hy     = hid_scale(clip_q[1]);
    dv_d[0].sx     = clip_q[0][CW-1];
    dv_d[0].sy     = clip_q[1][CW-1];
    dv_d[0].d      = clip_q[2];
    dv_d[0].rx     = r0x;
    dv_d[0].ry     = r0y;
    dv_d[0].remx   = npx[QUO_W-1:0];
    dv_d[0].remy   = npy[QUO_W-1:0];
    dv_d[0].qx     = '0;
    dv_d[0].qy     = '0;
    dv_d[0].ovx    = r0x >= RW'(clip_q[2]);
    dv_d[0].ovy    = r0y >= RW'(clip_q[2]);
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 1; k <= QUO_W; k++) begin : g_div
    logic [RW-1:0] shx, shy;
    always_comb begin
      dv_d[k] = dv_q[k-1];
      shx = {dv_q[k-1].rx[RW-2:0], dv_q[k-1].remx[QUO_W-1]};
      shy = {dv_q[k-1].ry[RW-2:0], dv_q[k-1].remy[QUO_W-1]};
      dv_d[k].remx = dv_q[k-1].remx << 1;
      dv_d[k].remy = dv_q[k-1].remy << 1;
      if (shx >= RW'(dv_q[k-1].d)) begin
        dv_d[k].rx = shx - RW'(dv_q[k-1].d);
        dv_d[k].qx = {dv_q[k-1].qx[QUO_W-2:0], 1'b1};
      end else begin
        dv_d[k].rx = shx;
        dv_d[k].qx = {dv_q[k-1].qx[QUO_W-2:0], 1'b0};
      end
      if (shy >= RW'(dv_q[k-1].d)) begin
        dv_d[k].ry = shy - RW'(dv_q[k-1].d);
        dv_d[k].qy = {dv_q[k-1].qy[QUO_W-2:0], 1'b1};
      end else begin
        dv_d[k].ry = shy;
        dv_d[k].qy = {dv_q[k-1].qy[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QUO_W; k++) dv_q[k] <= '0;
    end else if (adv) begin
      for (int k = 0; k <= QUO_W; k++) dv_q[k] <= dv_d[k];
    end
  end

  // offset stage
  logic                      t_valid_q, t_hidden_q;
  logic signed [COORD_W-1:0] t_hx_q, t_hy_q;
  logic signed [TW-1:0]      tx_q, ty_q;
  logic [QUO_W-1:0]          nmx, nmy;
  logic signed [TW-1:0]      ndx, ndy;

  always_comb begin
    nmx = (dv_q[QUO_W].ovx || dv_q[QUO_W].qx > NDC_LIMIT) ? NDC_LIMIT : dv_q[QUO_W].qx;
    nmy = (dv_q[QUO_W].ovy || dv_q[QUO_W].qy > NDC_LIMIT) ? NDC_LIMIT : dv_q[QUO_W].qy;
    ndx = dv_q[QUO_W].sx ? -TW'(nmx) : TW'(nmx);
    ndy = dv_q[QUO_W].sy ? -TW'(nmy) : TW'(nmy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t_valid_q <= 1'b0;
    else if (adv) t_valid_q <= dv_q[QUO_W].valid;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_hidden_q <= dv_q[QUO_W].hidden;
      t_hx_q     <= dv_q[QUO_W].hx;
      t_hy_q     <= dv_q[QUO_W].hy;
      tx_q       <= ONE + ndx;
      ty_q       <= ONE - ndy;
    end
  end

  // viewport multiply
  logic                      m_valid_q, m_hidden_q;
  logic signed [COORD_W-1:0] m_hx_q, m_hy_q;
  logic signed [PW-1:0]      px_q, py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_valid_q <= 1'b0;
    else if (adv) m_valid_q <= t_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_hidden_q <= t_hidden_q;
      m_hx_q     <= t_hx_q;
      m_hy_q     <= t_hy_q;
      px_q       <= PW'($signed({1'b0, width_q})) * PW'(tx_q);
      py_q       <= PW'($signed({1'b0, height_q})) * PW'(ty_q);
    end
  end

  // saturation and output register
  function automatic logic signed [COORD_W-1:0] sat_half(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] h;
    logic signed [COORD_W-1:0] res;
    h = v >>> 1;
    if (h > PW'(COORD_MAX)) res = COORD_MAX;
    else if (h < PW'(COORD_MIN)) res = COORD_MIN;
    else res = COORD_W'(h);
    return res;
  endfunction

  logic signed [COORD_W-1:0] sx_q, sy_q;
  logic                      vis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= m_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q  <= m_hidden_q ? m_hx_q : sat_half(px_q);
      sy_q  <= m_hidden_q ? m_hy_q : sat_half(py_q);
      vis_q <= !m_hidden_q;
    end
  end

  assign screen_o.valid    = out_valid_q;
  assign screen_o.screen_x = sx_q;
  assign screen_o.screen_y = sy_q;
  assign screen_o.visible  = vis_q;

  // checks
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_i.valid && point_i.ready |=> s1_valid_q)
    else $error("accepted point did not enter the pipeline");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !screen_o.ready |=> $stable(dv_q[QUO_W]) && $stable(px_q))
    else $error("pipeline moved during a stall");

  a_rem_below_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[QUO_W].valid && !dv_q[QUO_W].hidden && !dv_q[QUO_W].ovx
      |-> dv_q[QUO_W].rx < RW'(dv_q[QUO_W].d))
    else $error("divider remainder not below divisor");

endmodule

// ----- sim/world_to_screen_projection_unit_test.sv -----
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit_test
// self-checking bench: world points go in, screen results are compared field by
// field against an in-bench fixed-point projection model, over several view
// matrix and viewport settings with random stalls on both channels
// ----------------------------------------------------------------------------
module world_to_screen_projection_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wtsp_pkg::*;

  localparam int          FRAC       = 16;
  localparam longint      ONE        = longint'(1) << FRAC;
  localparam longint      W_FLOOR    = (ONE + 999) / 1000;
  localparam int          LAT        = 60;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          PHASES     = 14;
  localparam int          PHASE_LEN  = 103;
  localparam logic [63:0] UNIT_HI    = 64'h0001_0000_0000_0000;
  localparam logic [63:0] UNIT_LO    = 64'h0000_0000_0001_0000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef struct packed {
    coord_t sx;
    coord_t sy;
    logic   vis;
  } screen_t;
  typedef struct {
    coord_t  x;
    coord_t  y;
    coord_t  z;
    bit      typed;
    screen_t want;
  } point_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wtsp_point_if  pt();
  wtsp_screen_if sc();

  world_to_screen_projection_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .point_i     (pt),
    .screen_o    (sc)
  );

  logic [63:0]       view_pair[6];
  logic [VIEW_W-1:0] view_w;
  logic [VIEW_W-1:0] view_h;

  screen_t screen_due[$];
  int      mismatches;
  int      n_points;
  int      n_results;
  int      n_visible;
  bit      calm;
  int      hold_left;
  int      stall_left;
  int      idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model
  function automatic coord_t sat32(longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic longint clip_row(int r, coord_t x, coord_t y, coord_t z);
    coord_t m0, m1, m2, m3;
    logic signed [69:0] acc;
    logic signed [69:0] bias;
    m0 = view_pair[2*r][63:32];
    m1 = view_pair[2*r][31:0];
    m2 = view_pair[2*r+1][63:32];
    m3 = view_pair[2*r+1][31:0];
    acc  = longint'(m0) * longint'(x);
    acc  = acc + longint'(m1) * longint'(y);
    acc  = acc + longint'(m2) * longint'(z);
    bias = m3;
    acc  = acc + (bias <<< FRAC);
    acc  = acc >>> FRAC;
    return longint'(acc);
  endfunction

  function automatic coord_t hidden_coord(longint c);
    if (c > longint'(HIDDEN_LIMIT)) return COORD_MAX;
    if (c < -longint'(HIDDEN_LIMIT) - 1) return COORD_MIN;
    return sat32(c * longint'(HIDDEN_SCALE));
  endfunction

  function automatic longint ndc_quot(longint c, longint w);
    longint unsigned n;
    logic [79:0] num;
    logic [79:0] mag;
    n = (c < 0) ? -c : c;
    if (n / w >= (longint'(1) << (NDC_LIMIT_LOG2 - FRAC))) begin
      mag = 80'd1 << NDC_LIMIT_LOG2;
    end else begin
      num = n;
      mag = (num << FRAC) / w;
      if (mag > (80'd1 << NDC_LIMIT_LOG2)) mag = 80'd1 << NDC_LIMIT_LOG2;
    end
    return (c < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic screen_t project_point(coord_t x, coord_t y, coord_t z);
    screen_t s;
    longint cx, cy, cw, nx, ny;
    cx = clip_row(0, x, y, z);
    cy = clip_row(1, x, y, z);
    cw = clip_row(2, x, y, z);
    if (cw < W_FLOOR) begin
      s.sx  = hidden_coord(cx);
      s.sy  = hidden_coord(cy);
      s.vis = 1'b0;
    end else begin
      nx    = ndc_quot(cx, cw);
      ny    = ndc_quot(cy, cw);
      s.sx  = sat32((longint'(view_w) * (ONE + nx)) >>> 1);
      s.sy  = sat32((longint'(view_h) * (ONE - ny)) >>> 1);
      s.vis = 1'b1;
    end
    return s;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic write_reg(cfg_index_e idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == CFG_WIDTH) view_w = data[VIEW_W-1:0];
    else if (idx == CFG_HEIGHT) view_h = data[VIEW_W-1:0];
    else view_pair[idx] = data;
  endtask

  task automatic drain;
    while (screen_due.size() != 0) @(posedge clk_i);
    repeat (LAT) @(posedge clk_i);
  endtask

  task automatic load_view(logic [63:0] pairs[6], logic [VIEW_W-1:0] w,
                           logic [VIEW_W-1:0] h);
    drain();
    write_reg(CFG_ROW0_A, pairs[0]);
    write_reg(CFG_ROW0_B, pairs[1]);
    write_reg(CFG_ROW1_A, pairs[2]);
    write_reg(CFG_ROW1_B, pairs[3]);
    write_reg(CFG_ROW3_A, pairs[4]);
    write_reg(CFG_ROW3_B, pairs[5]);
    write_reg(CFG_WIDTH, 64'(w));
    write_reg(CFG_HEIGHT, 64'(h));
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic send_point(coord_t x, coord_t y, coord_t z, bit typed, screen_t want);
    pt.valid   <= 1'b1;
    pt.point_x <= x;
    pt.point_y <= y;
    pt.point_z <= z;
    @(posedge clk_i);
    while (!pt.ready) @(posedge clk_i);
    screen_due.push_back(typed ? want : project_point(x, y, z));
    n_points++;
  endtask

  task automatic sender_gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      pt.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] small_q(int unsigned span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  function automatic coord_t rand_coord(int unsigned flavour);
    case (flavour)
      0: return coord_t'($urandom);
      1: return coord_t'(small_q(200));
      default: return coord_t'(small_q(32'h0100_0000));
    endcase
  endfunction

  // receiver: random stall bursts, plus an explicit long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc.ready   <= 1'b0;
      stall_left <= 0;
    end else if (hold_left > 0) begin
      sc.ready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      sc.ready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      sc.ready   <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      sc.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && sc.valid && sc.ready) begin
      if (screen_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: sx=%0d sy=%0d vis=%0b",
                   sc.screen_x, sc.screen_y, sc.visible);
      end else begin
        screen_t want;
        want = screen_due.pop_front();
        n_results++;
        if (sc.visible) n_visible++;
        if (sc.screen_x !== want.sx || sc.screen_y !== want.sy ||
            sc.visible !== want.vis) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: want sx=%0d sy=%0d vis=%0b, got sx=%0d sy=%0d vis=%0b",
                     n_results, want.sx, want.sy, want.vis,
                     sc.screen_x, sc.screen_y, sc.visible);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pt.valid && pt.ready) || (sc.valid && sc.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("world_to_screen_projection_unit_test: errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  point_row_t point_rows[] = '{
    '{32'sd0, 32'sd0, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
    '{COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
    '{COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
    '{32'sd0, 32'sd0, 32'sd66, 1'b1, '{32'sd62914560, 32'sd35389440, 1'b1}},
    '{32'sd1, -32'sd1, 32'sd65, 1'b1, '{32'sd100000, -32'sd100000, 1'b0}},
    '{32'sd21475, 32'sd0, 32'sd0, 1'b1, '{COORD_MAX, 32'sd0, 1'b0}},
    '{-32'sd21476, 32'sd0, -32'sd5, 1'b1, '{COORD_MIN, 32'sd0, 1'b0}},
    '{32'sd65536, 32'sd65536, 32'sd65536, 1'b1, '{32'sd125829120, 32'sd0, 1'b1}},
    '{COORD_MAX, COORD_MIN, 32'sd66, 1'b0, '{32'sd0, 32'sd0, 1'b0}},
    '{COORD_MIN, COORD_MAX, COORD_MAX, 1'b0, '{32'sd0, 32'sd0, 1'b0}},
    '{32'sd123456, -32'sd654321, 32'sd300000, 1'b0, '{32'sd0, 32'sd0, 1'b0}},
    '{-32'sd1, 32'sd1, 32'sd66, 1'b0, '{32'sd0, 32'sd0, 1'b0}},
    '{32'sh4000_0000, -32'sh4000_0000, 32'sd70, 1'b0, '{32'sd0, 32'sd0, 1'b0}},
    '{32'sd0, 32'sd0, COORD_MIN, 1'b0, '{32'sd0, 32'sd0, 1'b0}},
    '{32'sd21474, -32'sd21475, -32'sd1, 1'b0, '{32'sd0, 32'sd0, 1'b0}}
  };

  initial begin
    logic [63:0]       pairs[6];
    logic [VIEW_W-1:0] w, h;
    int unsigned       flavour;
    screen_t           none;

    none        = '0;
    rst_ni      = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    pt.valid    = 1'b0;
    pt.point_x  = '0;
    pt.point_y  = '0;
    pt.point_z  = '0;
    calm        = 1'b0;
    hold_left   = 0;
    mismatches  = 0;
    n_points    = 0;
    n_results   = 0;
    n_visible   = 0;
    idle_cycles = 0;
    foreach (view_pair[i]) view_pair[i] = '0;
    view_w = WIDTH_RESET;
    view_h = HEIGHT_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset view: zero matrix, every point hidden at the origin
    for (int i = 0; i < 3; i++) begin
      send_point(point_rows[i].x, point_rows[i].y, point_rows[i].z,
                 point_rows[i].typed, point_rows[i].want);
      sender_gap();
    end
    pt.valid <= 1'b0;

    // plain perspective: w equals z
    pairs = '{UNIT_HI, 64'd0, UNIT_LO, 64'd0, 64'd0, UNIT_HI};
    load_view(pairs, WIDTH_RESET, HEIGHT_RESET);
    for (int i = 3; i < point_rows.size(); i++) begin
      send_point(point_rows[i].x, point_rows[i].y, point_rows[i].z,
                 point_rows[i].typed, point_rows[i].want);
      sender_gap();
    end
    pt.valid <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          foreach (pairs[i]) pairs[i] = '1;
          w = 15'd1;
          h = 15'd1;
        end
        1: begin
          foreach (pairs[i]) pairs[i] = 64'h7fff_ffff_8000_0000;
          w = 15'd16384;
          h = 15'd16384;
        end
        default: begin
          foreach (pairs[i]) begin
            if (ph % 5 == 4) pairs[i] = {$urandom, $urandom};
            else pairs[i] = {small_q(32'h0004_0000), small_q(32'h0004_0000)};
          end
          if (ph % 5 != 4) pairs[5][31:0] = small_q(32'h0010_0000) + 32'h0008_0000;
          w = 15'($urandom_range(1, 16384));
          h = 15'($urandom_range(1, 16384));
          if (ph == 2) begin
            w = 15'h7fff;
            h = 15'd0;
          end
        end
      endcase
      load_view(pairs, w, h);
      calm = (ph == PHASES - 1) || ($urandom_range(0, 3) == 0);
      if (ph == 3) hold_left = 150;
      for (int k = 0; k < PHASE_LEN; k++) begin
        if (ph == 5 && k == PHASE_LEN / 2) begin
          pt.valid <= 1'b0;
          while (screen_due.size() != 0) @(posedge clk_i);
        end
        flavour = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 2);
        send_point(rand_coord(flavour), rand_coord(flavour), rand_coord(flavour),
                   1'b0, none);
        sender_gap();
      end
      pt.valid <= 1'b0;
    end

    drain();
    $display("covered %0d points over %0d view settings, %0d visible and %0d hidden",
             n_points, PHASES + 2, n_visible, n_results - n_visible);
    if (mismatches == 0 && screen_due.size() == 0) begin
      $display("world_to_screen_projection_unit_test: clean");
    end else begin
      $display("mismatches %0d, still outstanding %0d", mismatches, screen_due.size());
      $display("world_to_screen_projection_unit_test: errors");
    end
    $finish;
  end

endmodule
